### rtl/vsc_pkg.sv
// Shared types, widths, register map and constants for the volume sphere cut.
// Used by every module of the block; depends on nothing.
package vsc_pkg;

    localparam int COMP_W    = 21;              // one Q10.10 component
    localparam int IDX_W     = 8;
    localparam int VAL_W     = 32;
    localparam int PACK_W    = 3 * COMP_W;
    localparam int RAD_W     = 21;
    localparam int R2_W      = 2 * RAD_W;
    localparam int PROD_W    = COMP_W + IDX_W + 1;
    localparam int DIFF_W    = 31;              // |position - centre| < 2^30
    localparam int SQ_W      = 61;              // sum of three squares
    localparam int ROOT_W    = 31;
    localparam int TERM_W    = 31;              // Q.30 value up to 1.0
    localparam int SUM_W     = 33;
    localparam int FRAC_W    = 10;
    localparam int WHOLE_W   = 4;
    localparam int FACT_W    = 17;              // 0..65536
    localparam int TAYLOR_N  = 14;
    localparam int WHOLE_MAX = 12;
    localparam int FLUSH_LIMIT = 12 * 1024;
    localparam int ADDR_W    = 6;
    localparam int DATA_W    = 64;
    localparam int REG_IDX_W = 3;

    localparam logic [TERM_W-1:0] ONE_Q30 = TERM_W'(1 << 30);

    localparam logic [REG_IDX_W-1:0] REG_AXIS_A = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_AXIS_B = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_AXIS_C = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CENTER = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_RADIUS = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_CUT    = 3'd5;

    typedef logic signed [COMP_W-1:0] comp_t;

    // Control that rides along with every voxel through the pipeline.
    typedef struct packed {
        logic                    valid;
        logic                    changed;
        logic                    scale;
        logic signed [VAL_W-1:0] value;
    } vsc_tag_t;

    function automatic comp_t comp_of(input logic [PACK_W-1:0] packed_v, input int k);
        return packed_v[k*COMP_W +: COMP_W];
    endfunction

    // exp(-1) in Q.30 as given by the truncating 14-term series at x = 1024
    localparam longint E1_Q30 = 395007543;

endpackage

### rtl/vsc_pos.sv
// Position and squared-distance stages: index products, centre offset, squares,
// sum and inside/outside decision. Depends on vsc_pkg.
module vsc_pos (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  vsc_pkg::vsc_tag_t                 in_tag,
    input  logic [vsc_pkg::IDX_W-1:0]         index_x,
    input  logic [vsc_pkg::IDX_W-1:0]         index_y,
    input  logic [vsc_pkg::IDX_W-1:0]         index_z,
    input  logic [vsc_pkg::PACK_W-1:0]        axis_a,
    input  logic [vsc_pkg::PACK_W-1:0]        axis_b,
    input  logic [vsc_pkg::PACK_W-1:0]        axis_c,
    input  logic [vsc_pkg::PACK_W-1:0]        center,
    input  logic [vsc_pkg::R2_W-1:0]          r2,
    input  logic                              inner_mode,
    output vsc_pkg::vsc_tag_t                 out_tag,
    output logic [vsc_pkg::SQ_W-1:0]          out_sumsq
);

    logic [vsc_pkg::IDX_W-1:0]               idx [3];
    logic [vsc_pkg::PACK_W-1:0]              ax  [3];
    logic signed [vsc_pkg::PROD_W-1:0]       prod_next [9];
    logic signed [vsc_pkg::PROD_W-1:0]       prod_reg  [9];
    logic signed [vsc_pkg::DIFF_W-1:0]       d_next [3];
    logic signed [vsc_pkg::DIFF_W-1:0]       d_reg  [3];
    logic signed [2*vsc_pkg::DIFF_W-1:0]     sq_full [3];
    logic [vsc_pkg::SQ_W-1:0]                sq_next [3];
    logic [vsc_pkg::SQ_W-1:0]                sq_reg  [3];
    logic [vsc_pkg::SQ_W-1:0]                sum_next;
    logic [vsc_pkg::SQ_W-1:0]                sum_reg;
    logic                                    outside;
    vsc_pkg::vsc_tag_t                       tag_next;
    vsc_pkg::vsc_tag_t                       tag_reg [4];

    assign idx[0] = index_x;
    assign idx[1] = index_y;
    assign idx[2] = index_z;
    assign ax[0]  = axis_a;
    assign ax[1]  = axis_b;
    assign ax[2]  = axis_c;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
                prod_next[3*j+k] = $signed({1'b0, idx[j]}) * vsc_pkg::comp_of(ax[j], k);
            end
        end
        for (int k = 0; k < 3; k++) begin
            d_next[k] = vsc_pkg::DIFF_W'(prod_reg[k]) + vsc_pkg::DIFF_W'(prod_reg[3+k])
                      + vsc_pkg::DIFF_W'(prod_reg[6+k])
                      - vsc_pkg::DIFF_W'(vsc_pkg::comp_of(center, k));
            sq_full[k] = d_reg[k] * d_reg[k];
            sq_next[k] = sq_full[k][vsc_pkg::SQ_W-1:0];
        end
        sum_next = sq_reg[0] + sq_reg[1] + sq_reg[2];
        outside  = sum_next > vsc_pkg::SQ_W'(r2);
        tag_next = tag_reg[2];
        if (inner_mode) begin
            tag_next.changed = !outside;
            tag_next.scale   = 1'b0;
            if (!outside) begin
                tag_next.value = '0;
            end
        end else begin
            tag_next.changed = outside;
            tag_next.scale   = outside;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < 4; s++) begin
                tag_reg[s] <= '0;
            end
        end else if (en) begin
            tag_reg[0] <= in_tag;
            tag_reg[1] <= tag_reg[0];
            tag_reg[2] <= tag_reg[1];
            tag_reg[3] <= tag_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
            d_reg    <= d_next;
            sq_reg   <= sq_next;
            sum_reg  <= sum_next;
        end
    end

    assign out_tag   = tag_reg[3];
    assign out_sumsq = sum_reg;

endmodule

### rtl/vsc_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on vsc_pkg.
module vsc_sqrt (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  vsc_pkg::vsc_tag_t              in_tag,
    input  logic [vsc_pkg::SQ_W-1:0]       sumsq,
    output vsc_pkg::vsc_tag_t              out_tag,
    output logic [vsc_pkg::ROOT_W-1:0]     root
);

    localparam int N_W   = 2 * vsc_pkg::ROOT_W;
    localparam int REM_W = vsc_pkg::ROOT_W + 3;

    logic [N_W-1:0]              n_reg    [vsc_pkg::ROOT_W];
    logic [REM_W-1:0]            rem_reg  [vsc_pkg::ROOT_W];
    logic [vsc_pkg::ROOT_W-1:0]  root_reg [vsc_pkg::ROOT_W];
    vsc_pkg::vsc_tag_t           tag_reg  [vsc_pkg::ROOT_W];

    for (genvar g = 0; g < vsc_pkg::ROOT_W; g++) begin : g_stage
        logic [N_W-1:0]             n_cur;
        logic [REM_W-1:0]           rem_cur;
        logic [vsc_pkg::ROOT_W-1:0] root_cur;
        vsc_pkg::vsc_tag_t          tag_cur;
        logic [REM_W-1:0]           rem2;
        logic [REM_W-1:0]           trial;
        logic                       ge;

        if (g == 0) begin : g_first
            assign n_cur    = N_W'(sumsq);
            assign rem_cur  = '0;
            assign root_cur = '0;
            assign tag_cur  = in_tag;
        end else begin : g_rest
            assign n_cur    = n_reg[g-1];
            assign rem_cur  = rem_reg[g-1];
            assign root_cur = root_reg[g-1];
            assign tag_cur  = tag_reg[g-1];
        end

        // bring down the next two bits and try root*4+1
        assign rem2  = {rem_cur[REM_W-3:0], n_cur[N_W-1 -: 2]};
        assign trial = {1'b0, root_cur, 2'b01};
        assign ge    = rem2 >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                tag_reg[g] <= '0;
            end else if (en) begin
                tag_reg[g] <= tag_cur;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[g]    <= n_cur << 2;
                rem_reg[g]  <= ge ? rem2 - trial : rem2;
                root_reg[g] <= {root_cur[vsc_pkg::ROOT_W-2:0], ge};
            end
        end
    end

    assign out_tag = tag_reg[vsc_pkg::ROOT_W-1];
    assign root    = root_reg[vsc_pkg::ROOT_W-1];

endmodule

### rtl/vsc_decay.sv
// Decay factor pipeline: excess over radius, exp(-frac) series, exp(-1) powers
// and rounding to a Q1.16 factor. Depends on vsc_pkg.
module vsc_decay (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  vsc_pkg::vsc_tag_t               in_tag,
    input  logic [vsc_pkg::ROOT_W-1:0]      root,
    input  logic [vsc_pkg::RAD_W-1:0]       radius,
    output vsc_pkg::vsc_tag_t               out_tag,
    output logic [vsc_pkg::FACT_W-1:0]      factor
);

    localparam int TW = vsc_pkg::TERM_W;
    localparam int MA_W = TW + vsc_pkg::FRAC_W;
    localparam logic [TW-2:0] E1 = (TW-1)'(vsc_pkg::E1_Q30);

    typedef struct packed {
        vsc_pkg::vsc_tag_t              tag;
        logic                           flush;
        logic [vsc_pkg::WHOLE_W-1:0]    whole;
    } car_t;

    // excess stage
    logic [vsc_pkg::ROOT_W:0]       diff;
    logic [vsc_pkg::ROOT_W-1:0]     e;
    car_t                           c0_next;
    car_t                           c0_reg;
    logic [vsc_pkg::FRAC_W-1:0]     x0_next;
    logic [vsc_pkg::FRAC_W-1:0]     x0_reg;

    // series stages
    logic [MA_W-1:0]                  ma_reg [vsc_pkg::TAYLOR_N];
    logic signed [vsc_pkg::SUM_W-1:0] sa_reg [vsc_pkg::TAYLOR_N];
    logic [vsc_pkg::FRAC_W-1:0]       xa_reg [vsc_pkg::TAYLOR_N];
    car_t                             ca_reg [vsc_pkg::TAYLOR_N];
    logic [TW-1:0]                    ab_reg [vsc_pkg::TAYLOR_N];
    logic [TW-1:0]                    q0_reg [vsc_pkg::TAYLOR_N];
    logic signed [vsc_pkg::SUM_W-1:0] sb_reg [vsc_pkg::TAYLOR_N];
    logic [vsc_pkg::FRAC_W-1:0]       xb_reg [vsc_pkg::TAYLOR_N];
    car_t                             cb_reg [vsc_pkg::TAYLOR_N];
    logic [TW-1:0]                    t_reg  [vsc_pkg::TAYLOR_N];
    logic signed [vsc_pkg::SUM_W-1:0] s_reg  [vsc_pkg::TAYLOR_N];
    logic [vsc_pkg::FRAC_W-1:0]       x_reg  [vsc_pkg::TAYLOR_N];
    car_t                             c_reg  [vsc_pkg::TAYLOR_N];

    // clamp, power chain, rounding
    logic [TW-1:0]                    fcl_next;
    logic [TW-1:0]                    fcl_reg;
    car_t                             ccl_reg;
    logic [TW-1:0]                    f_reg  [vsc_pkg::WHOLE_MAX];
    car_t                             cf_reg [vsc_pkg::WHOLE_MAX];
    logic [TW:0]                      rnd;
    logic [vsc_pkg::FACT_W-1:0]       factor_next;
    logic [vsc_pkg::FACT_W-1:0]       factor_reg;
    vsc_pkg::vsc_tag_t                tag_out_reg;

    always_comb begin
        diff = {1'b0, root} - (vsc_pkg::ROOT_W+1)'(radius);
        e    = (root > vsc_pkg::ROOT_W'(radius)) ? diff[vsc_pkg::ROOT_W-1:0] : '0;
        c0_next.tag   = in_tag;
        c0_next.flush = e > vsc_pkg::ROOT_W'(vsc_pkg::FLUSH_LIMIT);
        c0_next.whole = e[vsc_pkg::FRAC_W +: vsc_pkg::WHOLE_W];
        x0_next       = e[vsc_pkg::FRAC_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c0_reg <= '0;
        end else if (en) begin
            c0_reg <= c0_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x0_reg <= x0_next;
        end
    end

    for (genvar g = 0; g < vsc_pkg::TAYLOR_N; g++) begin : g_term
        localparam int K = g + 1;
        localparam logic [31:0] RECIP = 32'((64'd1 << 32) / K);
        localparam bit ODD = (K % 2) == 1;

        logic [TW-1:0]                    t_cur;
        logic signed [vsc_pkg::SUM_W-1:0] s_cur;
        logic [vsc_pkg::FRAC_W-1:0]       x_cur;
        car_t                             c_cur;
        logic [MA_W-1:0]                  ma_next;
        logic [TW-1:0]                    a_cur;
        logic [TW+31:0]                   recip_prod;
        logic [TW-1:0]                    q0_next;
        logic [TW+3:0]                    qk;
        logic [TW+3:0]                    r;
        logic [TW-1:0]                    q;
        logic signed [vsc_pkg::SUM_W-1:0] s_next;

        if (g == 0) begin : g_first
            assign t_cur = vsc_pkg::ONE_Q30;
            assign s_cur = vsc_pkg::SUM_W'(vsc_pkg::ONE_Q30);
            assign x_cur = x0_reg;
            assign c_cur = c0_reg;
        end else begin : g_rest
            assign t_cur = t_reg[g-1];
            assign s_cur = s_reg[g-1];
            assign x_cur = x_reg[g-1];
            assign c_cur = c_reg[g-1];
        end

        assign ma_next    = MA_W'(t_cur) * MA_W'(x_cur);
        assign a_cur      = ma_reg[g][vsc_pkg::FRAC_W +: TW];
        assign recip_prod = (TW+32)'(a_cur) * (TW+32)'(RECIP);

        if (K == 1) begin : g_unit
            assign q0_next = a_cur;
        end else begin : g_recip
            // estimate is exact or one low
            assign q0_next = recip_prod[32 +: TW];
        end

        assign qk     = (TW+4)'(q0_reg[g]) * (TW+4)'(K);
        assign r      = (TW+4)'(ab_reg[g]) - qk;
        assign q      = (r >= (TW+4)'(K)) ? q0_reg[g] + 1'b1 : q0_reg[g];
        assign s_next = ODD ? sb_reg[g] - $signed(vsc_pkg::SUM_W'(q))
                            : sb_reg[g] + $signed(vsc_pkg::SUM_W'(q));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ca_reg[g] <= '0;
                cb_reg[g] <= '0;
                c_reg[g]  <= '0;
            end else if (en) begin
                ca_reg[g] <= c_cur;
                cb_reg[g] <= ca_reg[g];
                c_reg[g]  <= cb_reg[g];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                ma_reg[g] <= ma_next;
                sa_reg[g] <= s_cur;
                xa_reg[g] <= x_cur;
                ab_reg[g] <= a_cur;
                q0_reg[g] <= q0_next;
                sb_reg[g] <= sa_reg[g];
                xb_reg[g] <= xa_reg[g];
                t_reg[g]  <= q;
                s_reg[g]  <= s_next;
                x_reg[g]  <= xb_reg[g];
            end
        end
    end

    always_comb begin
        if (s_reg[vsc_pkg::TAYLOR_N-1] < 0) begin
            fcl_next = '0;
        end else if (s_reg[vsc_pkg::TAYLOR_N-1] > $signed(vsc_pkg::SUM_W'(vsc_pkg::ONE_Q30))) begin
            fcl_next = vsc_pkg::ONE_Q30;
        end else begin
            fcl_next = s_reg[vsc_pkg::TAYLOR_N-1][TW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ccl_reg <= '0;
        end else if (en) begin
            ccl_reg <= c_reg[vsc_pkg::TAYLOR_N-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fcl_reg <= fcl_next;
        end
    end

    // multiply by exp(-1) once per whole unit of excess
    for (genvar g = 0; g < vsc_pkg::WHOLE_MAX; g++) begin : g_pow
        logic [TW-1:0]       f_cur;
        car_t                c_cur;
        logic [2*TW-2:0]     mul;
        logic [TW-1:0]       f_next;

        if (g == 0) begin : g_first
            assign f_cur = fcl_reg;
            assign c_cur = ccl_reg;
        end else begin : g_rest
            assign f_cur = f_reg[g-1];
            assign c_cur = cf_reg[g-1];
        end

        assign mul    = (2*TW-1)'(f_cur) * (2*TW-1)'(E1);
        assign f_next = (vsc_pkg::WHOLE_W'(g) < c_cur.whole) ? mul[30 +: TW] : f_cur;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                cf_reg[g] <= '0;
            end else if (en) begin
                cf_reg[g] <= c_cur;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                f_reg[g] <= f_next;
            end
        end
    end

    always_comb begin
        rnd         = (TW+1)'(f_reg[vsc_pkg::WHOLE_MAX-1]) + (TW+1)'(1 << 13);
        factor_next = cf_reg[vsc_pkg::WHOLE_MAX-1].flush ? '0 : rnd[14 +: vsc_pkg::FACT_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_out_reg <= '0;
        end else if (en) begin
            tag_out_reg <= cf_reg[vsc_pkg::WHOLE_MAX-1].tag;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            factor_reg <= factor_next;
        end
    end

    assign out_tag = tag_out_reg;
    assign factor  = factor_reg;

endmodule

### rtl/volume_sphere_cut.sv
// Top level of the volume sphere cut: register port, pipeline, scaling and
// output buffering. Depends on vsc_pkg, vsc_pos, vsc_sqrt and vsc_decay.
//
//   group     | direction | carries
//   s_*       | in        | tdata: voxel_value[31:0], index_x, index_y, index_z
//   m_*       | out       | tdata: new_value[31:0]; tuser: was_changed
//   p*        | in/out    | register writes and reads, 8 bytes per register
//
// One voxel enters per cycle while s_tready is high; the pipeline depth comes mostly
// from the 31-stage square root and the 42-stage exp series.
// Reset is synchronous, active low, and clears valid bits and registers.
// A full output register plus a full skid slot freezes the whole pipeline;
// s_tready is a registered signal and drops only then.
module volume_sphere_cut (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [55:0]                   s_tdata,   // voxel_value, index_x, index_y, index_z
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,   // new_value
    output logic                          m_tuser,   // was_changed
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vsc_pkg::ADDR_W-1:0]    paddr,
    input  logic [vsc_pkg::DATA_W-1:0]    pwdata,
    output logic [vsc_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    logic [vsc_pkg::PACK_W-1:0]  axis_a_reg;
    logic [vsc_pkg::PACK_W-1:0]  axis_b_reg;
    logic [vsc_pkg::PACK_W-1:0]  axis_c_reg;
    logic [vsc_pkg::PACK_W-1:0]  center_reg;
    logic [vsc_pkg::RAD_W-1:0]   radius_reg;
    logic                        cut_reg;
    logic [vsc_pkg::R2_W-1:0]    r2_reg;
    logic [vsc_pkg::REG_IDX_W-1:0] reg_idx;
    logic                        wr;

    logic                        en;
    vsc_pkg::vsc_tag_t           in_tag;
    vsc_pkg::vsc_tag_t           pos_tag;
    logic [vsc_pkg::SQ_W-1:0]    sumsq;
    vsc_pkg::vsc_tag_t           sqrt_tag;
    logic [vsc_pkg::ROOT_W-1:0]  root;
    vsc_pkg::vsc_tag_t           dec_tag;
    logic [vsc_pkg::FACT_W-1:0]  factor;

    logic signed [vsc_pkg::VAL_W+vsc_pkg::FACT_W:0] mprod_next;
    logic signed [vsc_pkg::VAL_W+vsc_pkg::FACT_W:0] mprod_reg;
    logic signed [vsc_pkg::VAL_W+vsc_pkg::FACT_W:0] rnd;
    vsc_pkg::vsc_tag_t           mtag_reg;
    logic [vsc_pkg::VAL_W-1:0]   fin_value;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [vsc_pkg::VAL_W-1:0]   out_value_reg;
    logic [vsc_pkg::VAL_W-1:0]   out_value_next;
    logic                        out_changed_reg;
    logic                        out_changed_next;
    logic                        skid_valid_reg;
    logic                        skid_valid_next;
    logic [vsc_pkg::VAL_W-1:0]   skid_value_reg;
    logic                        skid_changed_reg;
    logic                        fin_push;
    logic                        out_free;

    // register port
    assign reg_idx = paddr[vsc_pkg::ADDR_W-1:3];
    assign wr      = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_a_reg <= '0;
            axis_b_reg <= '0;
            axis_c_reg <= '0;
            center_reg <= '0;
            radius_reg <= '0;
            cut_reg    <= 1'b0;
            r2_reg     <= '0;
        end else begin
            r2_reg <= vsc_pkg::R2_W'(radius_reg) * vsc_pkg::R2_W'(radius_reg);
            if (wr) begin
                case (reg_idx)
                    vsc_pkg::REG_AXIS_A: axis_a_reg <= pwdata[vsc_pkg::PACK_W-1:0];
                    vsc_pkg::REG_AXIS_B: axis_b_reg <= pwdata[vsc_pkg::PACK_W-1:0];
                    vsc_pkg::REG_AXIS_C: axis_c_reg <= pwdata[vsc_pkg::PACK_W-1:0];
                    vsc_pkg::REG_CENTER: center_reg <= pwdata[vsc_pkg::PACK_W-1:0];
                    vsc_pkg::REG_RADIUS: radius_reg <= pwdata[vsc_pkg::RAD_W-1:0];
                    vsc_pkg::REG_CUT:    cut_reg    <= pwdata[0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        case (reg_idx)
            vsc_pkg::REG_AXIS_A: prdata = vsc_pkg::DATA_W'(axis_a_reg);
            vsc_pkg::REG_AXIS_B: prdata = vsc_pkg::DATA_W'(axis_b_reg);
            vsc_pkg::REG_AXIS_C: prdata = vsc_pkg::DATA_W'(axis_c_reg);
            vsc_pkg::REG_CENTER: prdata = vsc_pkg::DATA_W'(center_reg);
            vsc_pkg::REG_RADIUS: prdata = vsc_pkg::DATA_W'(radius_reg);
            vsc_pkg::REG_CUT:    prdata = vsc_pkg::DATA_W'(cut_reg);
            default:             prdata = '0;
        endcase
    end

    // pipeline
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    always_comb begin
        in_tag.valid   = s_tvalid;
        in_tag.changed = 1'b0;
        in_tag.scale   = 1'b0;
        in_tag.value   = s_tdata[31:0];
    end

    vsc_pos u_pos (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_tag     (in_tag),
        .index_x    (s_tdata[39:32]),
        .index_y    (s_tdata[47:40]),
        .index_z    (s_tdata[55:48]),
        .axis_a     (axis_a_reg),
        .axis_b     (axis_b_reg),
        .axis_c     (axis_c_reg),
        .center     (center_reg),
        .r2         (r2_reg),
        .inner_mode (cut_reg),
        .out_tag    (pos_tag),
        .out_sumsq  (sumsq)
    );

    vsc_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_tag  (pos_tag),
        .sumsq   (sumsq),
        .out_tag (sqrt_tag),
        .root    (root)
    );

    vsc_decay u_decay (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_tag  (sqrt_tag),
        .root    (root),
        .radius  (radius_reg),
        .out_tag (dec_tag),
        .factor  (factor)
    );

    assign mprod_next = dec_tag.value * $signed({1'b0, factor});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mtag_reg <= '0;
        end else if (en) begin
            mtag_reg <= dec_tag;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mprod_reg <= mprod_next;
        end
    end

    // round half up back to Q15.16
    assign rnd       = mprod_reg + (vsc_pkg::VAL_W+vsc_pkg::FACT_W+1)'(32768);
    assign fin_value = mtag_reg.scale ? rnd[16 +: vsc_pkg::VAL_W] : mtag_reg.value;

    // output register with one skid slot
    assign out_free = !out_valid_reg || m_tready;
    assign fin_push = en && mtag_reg.valid;

    always_comb begin
        out_valid_next   = out_valid_reg;
        out_value_next   = out_value_reg;
        out_changed_next = out_changed_reg;
        skid_valid_next  = skid_valid_reg;
        if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_next   = 1'b1;
                out_value_next   = skid_value_reg;
                out_changed_next = skid_changed_reg;
                skid_valid_next  = 1'b0;
            end else begin
                out_valid_next   = fin_push;
                out_value_next   = fin_value;
                out_changed_next = mtag_reg.changed;
            end
        end else if (fin_push) begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_value_reg   <= out_value_next;
        out_changed_reg <= out_changed_next;
        if (!out_free && fin_push) begin
            skid_value_reg   <= fin_value;
            skid_changed_reg <= mtag_reg.changed;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_changed_reg;

endmodule

### dv/volume_sphere_cut_tb.sv
// Self-checking bench for volume_sphere_cut: voxel stream in, cut voxel stream out.
// Needs every file under rtl/; computes expected voxels itself.
module volume_sphere_cut_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 200;
    localparam logic [62:0] PACK_MASK = {63{1'b1}};

    typedef struct {
        logic [31:0] value;
        logic [7:0]  ix;
        logic [7:0]  iy;
        logic [7:0]  iz;
    } voxel_t;

    typedef struct {
        logic [31:0] value;
        logic        changed;
    } cut_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;     // voxel_value, index_x, index_y, index_z
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // new_value
    logic        m_tuser;          // was_changed
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [vsc_pkg::ADDR_W-1:0] paddr = '0;
    logic [vsc_pkg::DATA_W-1:0] pwdata = '0;
    logic [vsc_pkg::DATA_W-1:0] prdata;
    logic        pready;

    volume_sphere_cut DUT (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // shadow copy of the register file
    logic [62:0] axis_a, axis_b, axis_c, center;
    logic [20:0] radius_q;
    logic        inner_sel;

    voxel_t voxel_q[$];
    cut_t   cut_q[$];
    int     pushed, accepted, received, errors, changed_cnt, cycles;
    bit     quiet;
    int     src_gap, snk_gap;

    function automatic longint comp(input logic [62:0] pk, input int k);
        logic signed [20:0] c;
        c = pk[k*21 +: 21];
        return c;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint exp_neg(input longint x);
        longint term, sum;
        term = longint'(1) << 30;
        sum = term;
        for (int k = 1; k <= 14; k++) begin
            term = (term * x) / (1024 * k);
            if (k % 2 == 1) sum -= term;
            else sum += term;
        end
        if (sum < 0) sum = 0;
        if (sum > (longint'(1) << 30)) sum = longint'(1) << 30;
        return sum;
    endfunction

    function automatic longint decay_factor(input longint unsigned e);
        longint unsigned f, e1;
        if (e > 12 * 1024) return 0;
        f = exp_neg(longint'(e & 1023));
        e1 = exp_neg(1024);
        for (longint unsigned i = 0; i < (e >> 10); i++) f = (f * e1) >> 30;
        return longint'((f + 8192) >> 14);
    endfunction

    function automatic cut_t cut_voxel(input voxel_t v);
        cut_t r;
        longint unsigned sumsq, r2, root_d, e;
        longint p, d, prod;
        logic signed [31:0] val;
        r.value = v.value;
        r.changed = 1'b0;
        sumsq = 0;
        r2 = longint'(radius_q) * longint'(radius_q);
        for (int k = 0; k < 3; k++) begin
            p = longint'(v.ix) * comp(axis_a, k) + longint'(v.iy) * comp(axis_b, k)
              + longint'(v.iz) * comp(axis_c, k);
            d = p - comp(center, k);
            sumsq += longint'(d * d);
        end
        if (inner_sel) begin
            if (sumsq <= r2) begin
                r.value = '0;
                r.changed = 1'b1;
            end
        end else if (sumsq > r2) begin
            root_d = int_sqrt(sumsq);
            e = root_d > radius_q ? root_d - radius_q : 0;
            val = v.value;
            prod = longint'(val) * decay_factor(e);
            prod = (prod + 32768) >>> 16;
            r.value = prod[31:0];
            r.changed = 1'b1;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("MISMATCH %s: got %h want %h (result %0d)", what, got, want, received);
    endtask

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("volume_sphere_cut_tb: done, errors");
            $finish;
        end
    end

    // source: hold a request until taken, then maybe idle before the next
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                accepted++;
                cut_q.insert(cut_q.size(), cut_voxel('{s_tdata[31:0], s_tdata[39:32],
                                                       s_tdata[47:40], s_tdata[55:48]}));
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 9) == 0) begin
                    src_gap = $urandom_range(0, 12);
                    s_tvalid <= 1'b0;
                end else if (voxel_q.size() > 0) begin
                    voxel_t v;
                    v = voxel_q.pop_front();
                    s_tdata <= {v.iz, v.iy, v.ix, v.value};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // sink: random stall bursts, then check each result against the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                received++;
                if (cut_q.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata, '0);
                end else begin
                    cut_t w;
                    w = cut_q.pop_front();
                    if (m_tdata !== w.value) report_mismatch("new_value", m_tdata, w.value);
                    if (m_tuser !== w.changed)
                        report_mismatch("was_changed", 32'(m_tuser), 32'(w.changed));
                    if (w.changed) changed_cnt++;
                end
            end
            if (snk_gap > 0) begin
                snk_gap--;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                snk_gap = $urandom_range(0, 12);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input logic [vsc_pkg::REG_IDX_W-1:0] idx,
                             input logic [63:0] data);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= vsc_pkg::ADDR_W'(idx) << 3;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            vsc_pkg::REG_AXIS_A: axis_a = data[62:0] & PACK_MASK;
            vsc_pkg::REG_AXIS_B: axis_b = data[62:0] & PACK_MASK;
            vsc_pkg::REG_AXIS_C: axis_c = data[62:0] & PACK_MASK;
            vsc_pkg::REG_CENTER: center = data[62:0];
            vsc_pkg::REG_RADIUS: radius_q = data[20:0];
            vsc_pkg::REG_CUT:    inner_sel = data[0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(input logic [63:0] a, input logic [63:0] b,
                                input logic [63:0] c, input logic [63:0] ctr,
                                input logic [63:0] rad, input logic inner);
        write_reg(vsc_pkg::REG_AXIS_A, a);
        write_reg(vsc_pkg::REG_AXIS_B, b);
        write_reg(vsc_pkg::REG_AXIS_C, c);
        write_reg(vsc_pkg::REG_CENTER, ctr);
        write_reg(vsc_pkg::REG_RADIUS, rad);
        write_reg(vsc_pkg::REG_CUT, {63'd0, inner});
    endtask

    task automatic drain();
        do @(negedge aclk);
        while (accepted != pushed || received != accepted || s_tvalid);
    endtask

    task automatic send(input logic [31:0] val, input int x, input int y, input int z);
        voxel_t v;
        v = '{val, 8'(x), 8'(y), 8'(z)};
        voxel_q.insert(voxel_q.size(), v);
        pushed++;
    endtask

    function automatic logic [20:0] rand_comp(input int mode);
        if (mode == 0) return 21'($urandom);
        return 21'($signed($urandom_range(0, 256)) - 128);
    endfunction

    function automatic logic [63:0] rand_vec(input int mode);
        return {$urandom_range(0, 1) == 1, rand_comp(mode), rand_comp(mode), rand_comp(mode)};
    endfunction

    initial begin
        logic [31:0] vals[6];
        axis_a = '0; axis_b = '0; axis_c = '0; center = '0; radius_q = '0; inner_sel = 1'b0;
        vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                 32'h0001_0000, 32'h0000_8000};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // reset registers: everything at the centre, nothing outside
        send(32'h1234_5678, 0, 0, 0);
        send(32'h8000_0000, 255, 255, 255);
        drain();

        // unit grid, radius 5: centre, on sphere, just outside, flush edge
        for (int inner = 0; inner < 2; inner++) begin
            set_geometry(64'd1024, 64'd1024 << 21, 64'd1024 << 42, '0, 64'd5 * 1024, inner);
            send(vals[0], 0, 0, 0);
            send(vals[1], 5, 0, 0);
            send(vals[2], 3, 4, 0);
            send(vals[3], 0, 0, 6);
            send(vals[4], 17, 0, 0);
            send(vals[5], 18, 0, 0);
            send(vals[0], 6, 0, 0);
            send(vals[1], 7, 0, 0);
            send(vals[4], 255, 255, 255);
            drain();
        end

        for (int ph = 0; ph < 10; ph++) begin
            int mode;
            int n;
            mode = (ph < 2) ? 0 : $urandom_range(0, 3);
            if (ph == 0) begin
                set_geometry('1, '1, '1, '1, '1, 1'b1);
            end else if (ph == 1) begin
                set_geometry(rand_vec(0), rand_vec(0), rand_vec(0), rand_vec(0),
                             64'h1F_FFFF, 1'b0);
            end else begin
                set_geometry(rand_vec(mode), rand_vec(mode), rand_vec(mode),
                             rand_vec(mode ? 1 : 0),
                             64'($urandom_range(0, 40 * 1024)), ph % 2);
            end
            quiet = (ph == 9);
            n = (ph < 2) ? 60 : 150;
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 3) == 0)
                    send($urandom, $urandom_range(0, 15), $urandom_range(0, 15),
                         $urandom_range(0, 15));
                else
                    send($urandom, $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255));
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("covered %0d voxels over 13 register settings, %0d modified by the cut",
                 received, changed_cnt);
        if (errors == 0 && cut_q.size() == 0) begin
            $display("volume_sphere_cut_tb: done, clean");
        end else begin
            $display("%0d mismatches, %0d predictions left", errors, cut_q.size());
            $display("volume_sphere_cut_tb: done, errors");
        end
        $finish;
    end

endmodule
